// File: sv/float32_normalize_round_pack_assert.svh
// Assertion macros used by the file that checks this block.
`ifndef FLOAT32_NORMALIZE_ROUND_PACK_ASSERT_SVH
`define FLOAT32_NORMALIZE_ROUND_PACK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with the consequent checked a delay after the antecedent, disabled while reset is asserted.
`define FNRP_ASSERT_DELAY4(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##4 (cons)) \
    else $error("assertion failed");

`endif

// File: sv/fnrp_pkg.sv
package fnrp_pkg;

  localparam int unsigned ManW     = 32;
  localparam int unsigned NormW    = 29;
  localparam int unsigned ExpW     = 10;
  localparam logic [7:0]  ExpSpecial = 8'hff;

  typedef enum logic [1:0] {
    KindNormal  = 2'd0,
    KindZero    = 2'd1,
    KindSpecial = 2'd2
  } kind_e;

  // Decoded word: raw fields plus leading-zero count.
  typedef struct packed {
    kind_e             kind;
    logic              sign;
    logic [7:0]        exp;
    logic [ManW-1:0]   man;
    logic [4:0]        lz;
  } dec_t;

  // Normalized or rounded word: leading one at bit 28, signed exponent.
  typedef struct packed {
    kind_e             kind;
    logic              sign;
    logic signed [ExpW-1:0] exp;
    logic [NormW-1:0]  man;
  } norm_t;

endpackage

// File: sv/fnrp_decode.sv
module fnrp_decode import fnrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] word_i,
  output logic        valid_o,
  output dec_t        dec_o
);

  logic        valid_q;
  dec_t        dec_d, dec_q;
  logic [31:0] man;
  logic [4:0]  lz;

  assign man = word_i[63:32];

  // Priority encode from the top: the highest set bit wins.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (man[i]) begin
        lz = 5'(31 - i);
      end
    end
  end

  always_comb begin
    dec_d.sign = word_i[10];
    dec_d.exp  = word_i[7:0];
    dec_d.man  = man;
    dec_d.lz   = lz;
    if (word_i[7:0] == ExpSpecial) begin
      dec_d.kind = KindSpecial;
    end else if (man == 32'd0) begin
      dec_d.kind = KindZero;
    end else begin
      dec_d.kind = KindNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// File: sv/fnrp_norm.sv
module fnrp_norm import fnrp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  dec_t  dec_i,
  output logic  valid_o,
  output norm_t norm_o
);

  logic        valid_q;
  norm_t       norm_d, norm_q;
  logic [4:0]  lsh;
  logic [31:0] shl;

  assign lsh = dec_i.lz - 5'd3;
  assign shl = dec_i.man << lsh;

  always_comb begin
    norm_d.kind = dec_i.kind;
    norm_d.sign = dec_i.sign;
    norm_d.exp  = $signed({2'b00, dec_i.exp}) + 10'sd3 - $signed({5'b00000, dec_i.lz});
    unique case (dec_i.lz)
      5'd0:    norm_d.man = dec_i.man[31:3] | {28'd0, |dec_i.man[2:0]};
      5'd1:    norm_d.man = dec_i.man[30:2] | {28'd0, |dec_i.man[1:0]};
      5'd2:    norm_d.man = dec_i.man[29:1] | {28'd0, dec_i.man[0]};
      default: norm_d.man = shl[28:0];
    endcase
    // Special words keep the raw mantissa for the fraction pass-through.
    if (dec_i.kind != KindNormal) begin
      norm_d.man = dec_i.man[28:0];
      norm_d.exp = $signed({2'b00, dec_i.exp});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;

endmodule

// File: sv/fnrp_round.sv
module fnrp_round import fnrp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  norm_t norm_i,
  output logic  valid_o,
  output norm_t rnd_o
);

  logic        valid_q;
  norm_t       rnd_d, rnd_q;
  logic [29:0] sum;

  assign sum = {1'b0, norm_i.man} + 30'd8;

  always_comb begin
    rnd_d = norm_i;
    // Round up on the guard bits except for an exact tie to an even lsb.
    if (norm_i.kind == KindNormal && norm_i.man[4:0] != 5'b01000) begin
      if (sum[29]) begin
        rnd_d.man = sum[29:1];
        rnd_d.exp = norm_i.exp + 10'sd1;
      end else begin
        rnd_d.man = sum[28:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
  end

  assign valid_o = valid_q;
  assign rnd_o   = rnd_q;

endmodule

// File: sv/fnrp_pack.sv
module fnrp_pack import fnrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  norm_t       rnd_i,
  output logic        valid_o,
  output logic [31:0] packed_o
);

  logic        valid_q;
  logic [31:0] packed_d, packed_q;
  logic signed [ExpW-1:0] den_sh_full;
  logic [4:0]  den_sh;
  logic [28:0] den_man;

  assign den_sh_full = 10'sd4 - rnd_i.exp;
  assign den_sh      = den_sh_full[4:0];
  assign den_man     = {rnd_i.man[28:4], 4'b0000} >> den_sh;

  always_comb begin
    unique case (rnd_i.kind)
      KindSpecial: packed_d = {rnd_i.sign, ExpSpecial, rnd_i.man[26:4]};
      KindZero:    packed_d = {rnd_i.sign, 31'd0};
      KindNormal: begin
        if (rnd_i.exp >= 10'sd255) begin
          packed_d = {rnd_i.sign, ExpSpecial, 23'd0};
        end else if (rnd_i.exp < 10'sd1) begin
          // Flush deep underflow, otherwise shift into the denormal range.
          if (rnd_i.exp < -10'sd24) begin
            packed_d = {rnd_i.sign, 31'd0};
          end else begin
            packed_d = {rnd_i.sign, 2'b00, den_man};
          end
        end else begin
          packed_d = {rnd_i.sign, rnd_i.exp[7:0], rnd_i.man[26:4]};
        end
      end
      default:     packed_d = {rnd_i.sign, 31'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    packed_q <= packed_d;
  end

  assign valid_o  = valid_q;
  assign packed_o = packed_q;

endmodule

// File: sv/float32_normalize_round_pack.sv
// done_o rises when an accepted word has passed the decode, normalize, round and pack registers.
// Throughput: one word per cycle through four register stages (decode and
// leading-zero count, normalize shift, round, pack); busy_o stays low.
// The receiver cannot stall; each packed word is shown for one cycle only.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
`include "float32_normalize_round_pack_assert.svh"

module float32_normalize_round_pack import fnrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] intermediate_word_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] packed_float_o
);

  logic  dec_valid, norm_valid, rnd_valid, accept;
  dec_t  dec;
  norm_t norm, rnd;

  // Every stage advances each cycle, so a new word is always taken.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  fnrp_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .word_i  (intermediate_word_i),
    .valid_o (dec_valid),
    .dec_o   (dec)
  );

  fnrp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (norm_valid),
    .norm_o  (norm)
  );

  fnrp_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .norm_i  (norm),
    .valid_o (rnd_valid),
    .rnd_o   (rnd)
  );

  fnrp_pack u_pack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rnd_valid),
    .rnd_i    (rnd),
    .valid_o  (done_o),
    .packed_o (packed_float_o)
  );

  `FNRP_ASSERT_DELAY4(a_accept_gives_done, clk_i, rst_ni, accept, done_o)
  `FNRP_ASSERT_IMPLY(a_done_has_source, clk_i, rst_ni, done_o, $past(accept, 4))
  `FNRP_ASSERT_IMPLY(a_sign_kept, clk_i, rst_ni, done_o, packed_float_o[31] == $past(intermediate_word_i[10], 4))
  `FNRP_ASSERT_IMPLY(a_special_exp, clk_i, rst_ni, done_o && $past(intermediate_word_i[7:0], 4) == ExpSpecial, packed_float_o[30:23] == ExpSpecial)

endmodule
